[hw/rtl/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants of the lru key-value cache: sizes, codes and the
// command that the top level broadcasts to the row of slot cells
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_pkg;

    // sizes
    localparam int ENTRIES   = 16;
    localparam int KEY_BITS  = 64;
    localparam int IN_KEY_BITS = 64;
    localparam int DATA_BITS = 64;
    localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);
    localparam int CAP_BITS  = 5;
    localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    // configuration port
    localparam int ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [ADDR_BITS-1:0] ADDR_CAPACITY = 3'd0;
    localparam logic [CAP_BITS-1:0]  CAPACITY_RESET = 5'd16;

    // item codes
    localparam logic OP_LOOKUP   = 1'b0;
    localparam logic OP_INSERT   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

    // sequencer states
    typedef enum logic
    {
        ST_IDLE,
        ST_BUSY
    } state_t;

    // command broadcast to every slot cell
    typedef struct packed
    {
        logic                 fire;
        logic                 insert;
        logic                 hit_any;
        logic [RANK_BITS-1:0] hit_rank;
        logic                 evict_en;
        logic [RANK_BITS-1:0] evict_rank;
    } cell_cmd_t;

endpackage

[hw/rtl/lkvc_cell.sv]
// ----------------------------------------------------------------------------
// lkvc_cell
// one cache slot: valid mark, key tag, data word and recency rank, with its
// own tag compare and its link in the free-slot claim chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lkvc_pkg::cell_cmd_t           cmd,
    input  logic [lkvc_pkg::KEY_BITS-1:0] key,
    input  logic [lkvc_pkg::DATA_BITS-1:0] data,
    input  logic                          claim_in,
    output logic                          claim_out,
    output logic                          hit,
    output logic [lkvc_pkg::DATA_BITS-1:0] hit_value,
    output logic [lkvc_pkg::RANK_BITS-1:0] hit_rank
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [lkvc_pkg::RANK_BITS-1:0]  rank_reg;
    logic [lkvc_pkg::RANK_BITS-1:0]  rank_next;
    logic [lkvc_pkg::KEY_BITS-1:0]   tag_reg;
    logic [lkvc_pkg::KEY_BITS-1:0]   tag_next;
    logic [lkvc_pkg::DATA_BITS-1:0]  value_reg;
    logic [lkvc_pkg::DATA_BITS-1:0]  value_next;
    logic                            evict_here;
    logic                            free_here;
    logic                            take;
    logic                            new_insert;

    // compare and claim chain
    always_comb
    begin
        hit        = valid_reg && (tag_reg == key);
        hit_value  = hit ? value_reg : '0;
        hit_rank   = hit ? rank_reg : '0;
        new_insert = cmd.insert && !cmd.hit_any;
        evict_here = cmd.evict_en && valid_reg && (rank_reg == cmd.evict_rank);
        free_here  = !valid_reg || evict_here;
        take       = new_insert && free_here && !claim_in;
        claim_out  = claim_in || free_here;
    end

    // slot update
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        tag_next   = tag_reg;
        value_next = value_reg;
        if (cmd.fire)
        begin
            if (cmd.hit_any)
            begin
                // hit: move to front, entries ahead of it slide back one place
                if (hit)
                begin
                    rank_next = '0;
                    if (cmd.insert)
                    begin
                        value_next = data;
                    end
                end
                else if (valid_reg && (rank_reg < cmd.hit_rank))
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            else if (cmd.insert)
            begin
                // new key: lowest free slot takes it, the rest age by one
                if (take)
                begin
                    valid_next = 1'b1;
                    rank_next  = '0;
                    tag_next   = key;
                    value_next = data;
                end
                else if (evict_here)
                begin
                    valid_next = 1'b0;
                end
                else if (valid_reg)
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        value_reg <= value_next;
    end

endmodule

[hw/rtl/lru_key_value_cache_top.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// In ST_IDLE the edge that accepts an item captures op, key and data; in ST_BUSY the
// key is compared against every slot cell at once and ranks, data and valid marks in
// the cell row are updated while the result is written to the output register. A
// result held by out_stall delays the update, so one item is in flight at a time; the
// next item is accepted while the previous result still waits. Reset clears all valid
// marks at once, so no clearing pass is needed.
module lru_key_value_cache_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lkvc_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [lkvc_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [lkvc_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready,
    // input items
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic [lkvc_pkg::IN_KEY_BITS-1:0]      lookup_key,
    input  logic [lkvc_pkg::DATA_BITS-1:0]        write_data,
    // result items
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  status,
    output logic [lkvc_pkg::DATA_BITS-1:0]        read_data
);

    lkvc_pkg::state_t                  state_reg;
    lkvc_pkg::state_t                  state_next;
    logic [lkvc_pkg::CAP_BITS-1:0]     cap_reg;
    logic [lkvc_pkg::CNT_BITS-1:0]     count_reg;
    logic [lkvc_pkg::CNT_BITS-1:0]     count_next;
    logic                              op_reg;
    logic [lkvc_pkg::KEY_BITS-1:0]     key_reg;
    logic [lkvc_pkg::DATA_BITS-1:0]    data_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              status_reg;
    logic [lkvc_pkg::DATA_BITS-1:0]    read_data_reg;
    logic                              accept;
    logic                              fire;
    logic                              cfg_write;
    logic [lkvc_pkg::CMP_BITS-1:0]     eff_cap;
    logic [lkvc_pkg::CMP_BITS-1:0]     count_ext;
    lkvc_pkg::cell_cmd_t               cmd;
    logic [lkvc_pkg::ENTRIES:0]        claim;
    logic [lkvc_pkg::ENTRIES-1:0]      hit_vec;
    logic [lkvc_pkg::DATA_BITS-1:0]    hit_value_arr [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::RANK_BITS-1:0]    hit_rank_arr [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::DATA_BITS-1:0]    hit_value;
    logic [lkvc_pkg::RANK_BITS-1:0]    hit_rank;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        if (paddr == lkvc_pkg::ADDR_CAPACITY)
        begin
            prdata = lkvc_pkg::APB_DATA_BITS'(cap_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkvc_pkg::CAPACITY_RESET;
        end
        else if (cfg_write && (paddr == lkvc_pkg::ADDR_CAPACITY))
        begin
            cap_reg <= pwdata[lkvc_pkg::CAP_BITS-1:0];
        end
    end

    // capacity clamped to 1 .. ENTRIES
    always_comb
    begin
        eff_cap   = lkvc_pkg::CMP_BITS'(cap_reg);
        count_ext = lkvc_pkg::CMP_BITS'(count_reg);
        if (cap_reg == '0)
        begin
            eff_cap = lkvc_pkg::CMP_BITS'(1);
        end
        else if (eff_cap > lkvc_pkg::CMP_BITS'(lkvc_pkg::ENTRIES))
        begin
            eff_cap = lkvc_pkg::CMP_BITS'(lkvc_pkg::ENTRIES);
        end
    end

    // handshake and sequencer
    assign in_stall  = (state_reg == lkvc_pkg::ST_BUSY);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign read_data = read_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        fire           = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lkvc_pkg::ST_BUSY;
                end
            end
            lkvc_pkg::ST_BUSY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fire           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lkvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkvc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            key_reg  <= lookup_key[lkvc_pkg::KEY_BITS-1:0];
            data_reg <= write_data;
        end
    end

    // hit reduction over the cell row
    always_comb
    begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        begin
            hit_value = hit_value | hit_value_arr[i];
            hit_rank  = hit_rank | hit_rank_arr[i];
        end
    end

    // command to the cells and entry count
    always_comb
    begin
        cmd.fire       = fire;
        cmd.insert     = (op_reg == lkvc_pkg::OP_INSERT);
        cmd.hit_any    = |hit_vec;
        cmd.hit_rank   = hit_rank;
        cmd.evict_en   = fire && cmd.insert && !cmd.hit_any && (count_ext >= eff_cap);
        cmd.evict_rank = lkvc_pkg::RANK_BITS'(count_reg - 1'b1);
        count_next     = count_reg;
        if (fire && cmd.insert && !cmd.hit_any && !cmd.evict_en)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (cmd.insert)
            begin
                status_reg    <= lkvc_pkg::STATUS_OK;
                read_data_reg <= '0;
            end
            else if (cmd.hit_any)
            begin
                status_reg    <= lkvc_pkg::STATUS_OK;
                read_data_reg <= hit_value;
            end
            else
            begin
                status_reg    <= lkvc_pkg::STATUS_MISS;
                read_data_reg <= '0;
            end
        end
    end

    // row of slot cells, free-slot claim passes from low to high index
    assign claim[0] = 1'b0;

    for (genvar g = 0; g < lkvc_pkg::ENTRIES; g++)
    begin : g_cell
        lkvc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .key       (key_reg),
            .data      (data_reg),
            .claim_in  (claim[g]),
            .claim_out (claim[g+1]),
            .hit       (hit_vec[g]),
            .hit_value (hit_value_arr[g]),
            .hit_rank  (hit_rank_arr[g])
        );
    end

`ifndef SYNTH
    // stored keys stay distinct, so at most one slot hits
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lkvc_pkg::ST_BUSY) |-> $countones(hit_vec) <= 1)
        else $error("more than one slot hit");

    // a new key always finds a free slot after any eviction
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd.insert && !cmd.hit_any) |-> claim[lkvc_pkg::ENTRIES])
        else $error("new key found no free slot");

    // the entry count never exceeds the slot count
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lkvc_pkg::CNT_BITS'(lkvc_pkg::ENTRIES))
        else $error("entry count overflow");

    // a fresh result only follows an update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(fire))
        else $error("result appeared without an update");
`endif

endmodule

[tb/sv/lkvc_tb_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_tb_pkg
// shadow copy of the lru key-value cache used to predict every result item and
// to compare the results that leave the block against those predictions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_tb_pkg;

    import lkvc_pkg::*;

    // one predicted result item
    typedef struct
    {
        logic                 status;
        logic [DATA_BITS-1:0] read_data;
    } cache_reply_t;

    class cache_mirror;

        bit                   slot_used [ENTRIES];
        logic [KEY_BITS-1:0]  slot_key  [ENTRIES];
        logic [DATA_BITS-1:0] slot_data [ENTRIES];
        int unsigned          slot_age  [ENTRIES];
        logic [CAP_BITS-1:0]  capacity;
        cache_reply_t         expected_replies [$];
        int                   mismatches;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_data[i] = '0;
                slot_age[i]  = 0;
            end
            capacity   = CAPACITY_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [APB_DATA_BITS-1:0] value);
            capacity = value[CAP_BITS-1:0];
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function int find_key(logic [KEY_BITS-1:0] key);
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && slot_key[i] == key)
                    return i;
            return -1;
        endfunction

        // entries more recent than s move down one place, s becomes most recent
        function void make_recent(int s);
            int unsigned age;
            age = slot_age[s];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && slot_age[i] < age)
                    slot_age[i]++;
            slot_age[s] = 0;
        endfunction

        // zero acts as one, anything above the slot count acts as the slot count
        function int unsigned usable_capacity();
            int unsigned c;
            c = capacity;
            if (c < 1)
                c = 1;
            if (c > ENTRIES)
                c = ENTRIES;
            return c;
        endfunction

        // new key: drop the oldest entry when full, then take the lowest free slot
        function void add_entry(logic [KEY_BITS-1:0] key, logic [DATA_BITS-1:0] data);
            int unsigned count;
            int          oldest;
            count  = 0;
            oldest = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i])
                    count++;
            if (count >= usable_capacity() && count > 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
                        oldest = i;
                if (oldest >= 0)
                    slot_used[oldest] = 1'b0;
            end
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i])
                    slot_age[i]++;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!slot_used[i])
                begin
                    slot_used[i] = 1'b1;
                    slot_key[i]  = key;
                    slot_data[i] = data;
                    slot_age[i]  = 0;
                    return;
                end
            end
        endfunction

        // apply one accepted item and queue the result it must produce
        function void note_request(logic op_in, logic [IN_KEY_BITS-1:0] key_in,
                                   logic [DATA_BITS-1:0] data_in);
            logic [KEY_BITS-1:0] key;
            int                  s;
            cache_reply_t        reply;
            key = key_in[KEY_BITS-1:0];
            s   = find_key(key);
            reply.status    = STATUS_OK;
            reply.read_data = '0;
            if (op_in == OP_LOOKUP)
            begin
                if (s >= 0)
                begin
                    make_recent(s);
                    reply.read_data = slot_data[s];
                end
                else
                    reply.status = STATUS_MISS;
            end
            else if (s >= 0)
            begin
                make_recent(s);
                slot_data[s] = data_in;
            end
            else
                add_entry(key, data_in);
            expected_replies.push_back(reply);
        endfunction

        // compare one accepted result item with the oldest prediction
        function void check_reply(logic status_in, logic [DATA_BITS-1:0] data_in);
            cache_reply_t want;
            if (expected_replies.size() == 0)
            begin
                $error("result item with none expected: status %0b read_data %h",
                       status_in, data_in);
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            if (status_in !== want.status)
            begin
                $error("status mismatch: expected %0b, actual %0b", want.status, status_in);
                mismatches++;
            end
            if (data_in !== want.read_data)
            begin
                $error("read_data mismatch: expected %h, actual %h",
                       want.read_data, data_in);
                mismatches++;
            end
        endfunction

    endclass

endpackage

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// lru key-value cache: directed lookups and inserts covering empty, update,
// fill and eviction, then random phases over several capacity settings with
// random gaps on the item side and random stalls on the result side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import lkvc_pkg::*;
    import lkvc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 86;
    localparam int SQUEEZE_CYCLES = 400;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_BITS-1:0]     paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_stall;
    logic                     op;
    logic [IN_KEY_BITS-1:0]   lookup_key;
    logic [DATA_BITS-1:0]     write_data;
    logic                     out_valid;
    logic                     out_stall;
    logic                     status;
    logic [DATA_BITS-1:0]     read_data;

    cache_mirror mirror = new();
    bit          squeeze_replies = 1'b0;
    int          cycle_count = 0;

    lru_key_value_cache_top u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .lookup_key (lookup_key),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_data  (read_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // accepted items feed the mirror, accepted results are checked
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            mirror.note_request(op, lookup_key, write_data);
        if (rst_n && out_valid && !out_stall)
            mirror.check_reply(status, read_data);
    end

    // result side: runs of free flow, random stalls and solid stalls
    initial
    begin
        int run_len;
        int mode;
        out_stall <= 1'b0;
        forever
        begin
            if (squeeze_replies)
            begin
                for (int i = 0; i < SQUEEZE_CYCLES; i++)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
                squeeze_replies = 1'b0;
            end
            run_len = $urandom_range(1, 40);
            mode    = $urandom_range(0, 99);
            for (int i = 0; i < run_len; i++)
            begin
                @(posedge clk);
                if (mode < 40)
                    out_stall <= 1'b0;
                else if (mode < 85)
                    out_stall <= ($urandom_range(0, 99) < 35);
                else
                    out_stall <= 1'b1;
            end
        end
    end

    function automatic logic [DATA_BITS-1:0] random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 8)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // offer one item and hold it until accepted
    task automatic send_item(input logic op_v, input logic [IN_KEY_BITS-1:0] key_v,
                             input logic [DATA_BITS-1:0] data_v);
        in_valid   <= 1'b1;
        op         <= op_v;
        lookup_key <= key_v;
        write_data <= data_v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // mostly back to back, sometimes short gaps, rarely long ones
    task automatic item_gap();
        int r;
        int cycles;
        r = $urandom_range(0, 99);
        if (r < 55)
            cycles = 0;
        else if (r < 92)
            cycles = $urandom_range(1, 3);
        else
            cycles = $urandom_range(10, 40);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // stop offering and wait for every predicted result
    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= {{(APB_DATA_BITS-CAP_BITS){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror.set_capacity({{(APB_DATA_BITS-CAP_BITS){1'b0}}, value});
    endtask

    // random traffic over a small key pool so hits, updates and evictions happen
    task automatic run_phase(input int pool_size, input int squeeze_at);
        logic [IN_KEY_BITS-1:0] pool [24];
        logic [IN_KEY_BITS-1:0] key_v;
        int                     r;
        for (int i = 0; i < pool_size; i++)
        begin
            r = $urandom_range(0, 15);
            if (r == 0)
                pool[i] = '0;
            else if (r == 1)
                pool[i] = '1;
            else
                pool[i] = {$urandom, $urandom};
        end
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) < 10)
                key_v = {$urandom, $urandom};
            else
                key_v = pool[$urandom_range(0, pool_size - 1)];
            send_item($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, key_v, random_word());
            if (n == squeeze_at)
                squeeze_replies = 1'b1;
            item_gap();
        end
        drain_replies();
    endtask

    // main sequence
    initial
    begin
        logic [CAP_BITS-1:0] phase_cap  [PHASES];
        int                  phase_pool [PHASES];
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        in_valid   <= 1'b0;
        op         <= OP_LOOKUP;
        lookup_key <= '0;
        write_data <= '0;
        phase_cap  = '{5'd1, 5'd0, 5'd4, 5'd31, 5'd16, 5'd2, 5'd17};
        phase_pool = '{3, 3, 7, 20, 19, 5, 18};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty lookup, extreme keys and data, update, fill, evict
        send_item(OP_LOOKUP, 64'h1234_5678_9abc_def0, '1);
        item_gap();
        send_item(OP_INSERT, '0, '1);
        send_item(OP_INSERT, '1, '0);
        item_gap();
        send_item(OP_LOOKUP, '0, 64'hdead_beef_0000_0001);
        send_item(OP_LOOKUP, '1, '0);
        send_item(OP_INSERT, '0, 64'h5555_aaaa_5555_aaaa);
        send_item(OP_LOOKUP, '0, '0);
        send_item(OP_LOOKUP, 64'h8000_0000_0000_0000, '1);
        for (int i = 0; i < ENTRIES - 2; i++)
        begin
            send_item(OP_INSERT, {$urandom, 24'h0, i[7:0]}, {$urandom, $urandom});
            item_gap();
        end
        // cache full: the oldest key, all ones, is evicted
        send_item(OP_INSERT, 64'h0f0f_0f0f_f0f0_f0f0, '1);
        send_item(OP_LOOKUP, '1, '0);
        drain_replies();

        // random phases, capacity changed only while idle
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_cap[p]);
            @(posedge clk);
            run_phase(phase_pool[p], (p == 3) ? 30 : -1);
        end

        repeat (10) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
